// ===== rtl/srw_pkg.sv =====
// ----------------------------------------------------------------------------
// srw_pkg
// Types, codes and constants shared by the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srw_pkg;

  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 14;
  localparam int HND_W  = 16;
  localparam int STAT_W = 2;

  localparam int WINDOW_DEF      = 32;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_END_SEQUENCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 2'd1;

  localparam logic [SEQ_W-1:0] END_SEQ_RESET = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 14'd10024;
  localparam logic [LEN_W-1:0] MIN_LENGTH    = 14'd5;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_NONE     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_IN_ORDER = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OUT_ORDER = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_IGNORED  = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_END      = 2'd3;

  typedef struct packed {
    logic [SEQ_W-1:0] sequence_req;
    logic [LEN_W-1:0] length;
    logic             checksum_good;
    logic [HND_W-1:0] payload_handle;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  serial;
    logic [HND_W-1:0]  out_handle;
    logic [LEN_W-1:0]  out_length;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_item_t;

  // request that passed the stateless checks
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] length;
    logic [HND_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic busy;
  } back_stat_t;

endpackage

// ===== rtl/srw_fifo.sv =====
// ----------------------------------------------------------------------------
// srw_fifo
// Small synchronous queue with full/empty flags.
// ----------------------------------------------------------------------------
module srw_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                store_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;
  logic [AW-1:0]   wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/srw_front.sv =====
// ----------------------------------------------------------------------------
// srw_front
// Accepts packet descriptors and drops null and corrupt ones.
// ----------------------------------------------------------------------------
module srw_front (
  input  logic                        in_push,
  input  srw_pkg::in_item_t           in_item,
  input  logic [srw_pkg::LEN_W-1:0]   max_length,
  input  logic                        cmd_full,
  output logic                        cmd_push,
  output srw_pkg::cmd_t               cmd
);

  import srw_pkg::*;

  logic accept;
  logic corrupt;
  logic null_seq;

  assign accept   = in_push && !cmd_full;
  assign null_seq = (in_item.sequence_req == '0);
  assign corrupt  = !in_item.checksum_good || (in_item.length < MIN_LENGTH) ||
                    (in_item.length >= max_length);

  // drop without a trace; only clean requests reach the window
  assign cmd_push = accept && !null_seq && !corrupt;

  assign cmd.seq    = in_item.sequence_req;
  assign cmd.length = in_item.length;
  assign cmd.handle = in_item.payload_handle;

endmodule

// ===== rtl/srw_back.sv =====
// ----------------------------------------------------------------------------
// srw_back
// Window state, slot memory, in-order drain and acknowledgement sequencer.
// ----------------------------------------------------------------------------
module srw_back #(
  parameter int WINDOW      = srw_pkg::WINDOW_DEF,
  parameter int HANDLE_BITS = srw_pkg::HANDLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  srw_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  input  logic [srw_pkg::SEQ_W-1:0]  end_sequence,
  input  logic                       out_full,
  output logic                       out_push,
  output srw_pkg::out_item_t         out_item,
  output srw_pkg::back_stat_t        stat
);

  import srw_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam int MEM_W = HANDLE_BITS + LEN_W;
  localparam logic [IDX_W:0] WIN_L = (IDX_W + 1)'(WINDOW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DELIVER,
    S_ACK
  } state_t;

  state_t              state_r;
  logic [SEQ_W-1:0]    low_r;
  logic [IDX_W-1:0]    ptr_r;
  logic [WINDOW-1:0]   present_r;
  logic                finished_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [SEQ_W-1:0]    ack_serial_r;
  logic [STAT_W-1:0]   ack_status_r;
  logic [MEM_W-1:0]    rd_r;
  logic [MEM_W-1:0]    slot_mem [WINDOW];

  logic [SEQ_W-1:0]    off;
  logic                in_win;
  logic [IDX_W:0]      phys_sum;
  logic [IDX_W:0]      phys_adj;
  logic [IDX_W-1:0]    phys;
  logic [IDX_W-1:0]    ptr_inc;
  logic                store;
  logic                mem_we;
  logic [MEM_W-1:0]    wr_data;
  logic [31:0]         wr_h32;
  logic [31:0]         rd_h32;
  logic                deliver_fire;
  logic [IDX_W-1:0]    rd_addr;

  assign off      = cmd.seq - low_r;
  assign in_win   = (off < SEQ_W'(WINDOW));
  assign phys_sum = {1'b0, ptr_r} + {1'b0, off[IDX_W-1:0]};
  assign phys_adj = phys_sum - WIN_L;
  assign phys     = (phys_sum >= WIN_L) ? phys_adj[IDX_W-1:0] : phys_sum[IDX_W-1:0];
  assign ptr_inc  = (ptr_r == IDX_W'(WINDOW - 1)) ? '0 : ptr_r + IDX_W'(1);
  assign store    = in_win && !present_r[phys];

  assign wr_h32  = 32'(cmd.handle);
  assign wr_data = {wr_h32[HANDLE_BITS-1:0], cmd.length};
  assign rd_h32  = 32'(rd_r[MEM_W-1:LEN_W]);

  assign cmd_pop      = (state_r == S_IDLE) && cmd_valid;
  assign mem_we       = cmd_pop && !finished_r && store;
  assign out_push     = (state_r == S_DELIVER) || (state_r == S_ACK);
  assign deliver_fire = (state_r == S_DELIVER) && !out_full;
  // read ahead at the next slot while a delivery goes out
  assign rd_addr      = deliver_fire ? ptr_inc : ptr_r;

  assign stat.finished = finished_r;
  assign stat.busy     = (state_r != S_IDLE);

  always_comb begin
    out_item.kind       = KIND_ACK;
    out_item.serial     = ack_serial_r;
    out_item.out_handle = '0;
    out_item.out_length = '0;
    out_item.status     = ack_status_r;
    out_item.last       = 1'b1;
    if (state_r == S_DELIVER) begin
      out_item.kind       = KIND_DELIVER;
      out_item.serial     = low_r;
      out_item.out_handle = rd_h32[HND_W-1:0];
      out_item.out_length = rd_r[LEN_W-1:0];
      out_item.status     = STATUS_NONE;
      out_item.last       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      low_r      <= SEQ_W'(1);
      ptr_r      <= '0;
      present_r  <= '0;
      finished_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_valid && !finished_r) begin
            seq_r <= cmd.seq;
            if (store) begin
              present_r[phys] <= 1'b1;
              state_r         <= S_READ;
            end else if (cmd.seq == end_sequence) begin
              ack_serial_r <= cmd.seq;
              ack_status_r <= STATUS_END;
              finished_r   <= 1'b1;
              state_r      <= S_ACK;
            end else begin
              ack_serial_r <= low_r - SEQ_W'(1);
              ack_status_r <= STATUS_IGNORED;
              state_r      <= S_ACK;
            end
          end
        end
        S_READ: begin
          if (present_r[ptr_r]) begin
            state_r <= S_DELIVER;
          end else begin
            ack_serial_r <= low_r - SEQ_W'(1);
            ack_status_r <= (low_r == seq_r + SEQ_W'(1)) ? STATUS_IN_ORDER
                                                           : STATUS_OUT_ORDER;
            state_r      <= S_ACK;
          end
        end
        S_DELIVER: begin
          if (!out_full) begin
            present_r[ptr_r] <= 1'b0;
            ptr_r            <= ptr_inc;
            low_r            <= low_r + SEQ_W'(1);
            if (!present_r[ptr_inc]) begin
              // new low edge is low_r + 1, so the ack names low_r
              ack_serial_r <= low_r;
              ack_status_r <= (low_r == seq_r) ? STATUS_IN_ORDER : STATUS_OUT_ORDER;
              state_r      <= S_ACK;
            end
          end
        end
        S_ACK: begin
          if (!out_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[phys] <= wr_data;
    end
    rd_r <= slot_mem[rd_addr];
  end

endmodule

// ===== rtl/selective_repeat_receive_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver side of a selective-repeat window with cumulative acknowledgement.
// ----------------------------------------------------------------------------
// A packet request with sequence zero or that is corrupt (bad checksum, or a
// length outside 5 up to max_length - 1) gives no result. Any other request
// goes through a two-entry queue to the window sequencer: a duplicate,
// out-of-window or end packet gives one acknowledgement; a newly stored packet
// gives n in-order deliveries, one delivery per cycle while the output queue
// has room, then the acknowledgement. After the end packet, requests give no
// result. The sequencer's single read port on the slot memory is registered,
// so a read state comes before the first delivery. Results wait in a
// two-entry output queue. Presence marks reset at once; no clearing pass.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window #(
  parameter int WINDOW      = srw_pkg::WINDOW_DEF,
  parameter int HANDLE_BITS = srw_pkg::HANDLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  srw_pkg::in_item_t               in_item,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output srw_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [srw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import srw_pkg::*;

  logic [SEQ_W-1:0] end_seq_r;
  logic [LEN_W-1:0] max_len_r;

  logic       cmd_push;
  cmd_t       cmd_in;
  logic       cmd_full;
  logic       cmd_pop;
  cmd_t       cmd_out;
  logic       cmd_empty;
  logic       back_push;
  out_item_t  back_item;
  logic       back_full;
  back_stat_t back_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_seq_r <= END_SEQ_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_END_SEQUENCE: end_seq_r <= cfg_data[SEQ_W-1:0];
        CFG_MAX_LENGTH:   max_len_r <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_full = cmd_full;

  srw_front u_front (
    .in_push    (in_push),
    .in_item    (in_item),
    .max_length (max_len_r),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  srw_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  srw_back #(
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (!cmd_empty),
    .cmd          (cmd_out),
    .cmd_pop      (cmd_pop),
    .end_sequence (end_seq_r),
    .out_full     (back_full),
    .out_push     (back_push),
    .out_item     (back_item),
    .stat         (back_stat)
  );

  srw_fifo #(
    .T     (out_item_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_push),
    .din   (back_item),
    .full  (back_full),
    .pop   (out_pop),
    .dout  (out_item),
    .empty (out_empty)
  );

`ifndef SYNTHESIS
  a_finished_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.finished |=> back_stat.finished)
    else $error("finished flag dropped without reset");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !back_stat.busy |-> !back_push)
    else $error("result produced while sequencer idle");

  a_delivery_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == KIND_DELIVER) |->
      (!out_item.last && out_item.status == STATUS_NONE))
    else $error("delivery carries ack fields");

  a_no_pop_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (back_stat.finished && !back_stat.busy) |-> !back_push)
    else $error("result after end of transfer");
`endif

endmodule
